FILE: design/pic_mixed_rle_line_decoder_assert.svh
// assertion helpers for the run-length line decoder
`ifndef PIC_MIXED_RLE_LINE_DECODER_ASSERT_SVH
`define PIC_MIXED_RLE_LINE_DECODER_ASSERT_SVH

// same-cycle implication, gated off by the disable condition
`define PIC_RLE_ASSERT_SAME(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("pic_rle: same-cycle check failed");

// next-cycle implication, gated off by the disable condition
`define PIC_RLE_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("pic_rle: next-cycle check failed");

`endif

FILE: design/pic_rle_pkg.sv
`default_nettype none

package pic_rle_pkg;

    localparam logic [2:0]  MAX_CHANNELS = 3'd4;
    localparam logic [7:0]  LONG_HEADER  = 8'd128;
    localparam logic [15:0] RUN_BIAS     = 16'd127;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_LINE_WIDTH       = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT    = 2'd1;
    localparam logic [1:0] REG_COUNT_HIGH_FIRST = 2'd2;

    // result status codes
    localparam logic [1:0] ST_PIXELS     = 2'd0;
    localparam logic [1:0] ST_LINE_DONE  = 2'd1;
    localparam logic [1:0] ST_MID_PACKET = 2'd2;
    localparam logic [1:0] ST_SHORT_LINE = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_COUNT_A = 3'd1,
        PH_COUNT_B = 3'd2,
        PH_RUN_PIX = 3'd3,
        PH_RAW_PIX = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  chan0;
        logic [7:0]  chan1;
        logic [7:0]  chan2;
        logic [7:0]  chan3;
        logic [15:0] repeat_res;
        logic [15:0] start_pixel;
        logic [1:0]  status;
        logic        last_of_step;
    } out_item_t;

    typedef struct packed {
        logic [15:0] line_width;
        logic [2:0]  channel_count;
        logic        count_high_first;
    } cfg_t;

    // results produced by one input byte
    typedef struct packed {
        logic [1:0] cnt;
        out_item_t  res0;
        out_item_t  res1;
    } push_t;

endpackage

`default_nettype wire

FILE: design/pic_mixed_rle_line_decoder.sv
// Mixed run-length scan line decoder.
// Input channel s_*: one compressed byte per item, final_byte marks the last
// byte available. Result channel m_*: pixel results (a pixel value with its
// repeat count and start position in the line) and status results (line
// complete, input ended mid packet, input ended before the line was full).
// Configuration is written over the APB port, by the user only while no item
// is in flight (not enforced): line_width at 0x0, channel_count at 0x4,
// count_high_first at 0x8. A byte's results are queued as it is accepted and
// reach m_* in order. One byte per cycle while s_ready is high; the decode
// state updates in the cycle the byte is taken. A byte that gives two results
// (last pixel plus a status) puts both into the four-entry queue at once.
// s_ready is low while the queue holds three or more results, so a stalled
// receiver stops input once three results wait, and nothing is lost.
// Reset (aresetn low, synchronous) empties the queue, clears the decode state
// to await a packet header at line position zero, and restores the registers
// to line_width 1, channel_count 4, count_high_first 1.
`default_nettype none

module pic_mixed_rle_line_decoder (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire pic_rle_pkg::in_item_t  s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output pic_rle_pkg::out_item_t      m_data,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [3:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pic_rle_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  wr_en;
    logic  in_fire;
    logic  room;
    push_t push;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign s_ready = room;
    assign in_fire = s_valid && s_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                REG_LINE_WIDTH:       cfg_next.line_width       = pwdata[15:0];
                REG_CHANNEL_COUNT:    cfg_next.channel_count    = pwdata[2:0];
                REG_COUNT_HIGH_FIRST: cfg_next.count_high_first = pwdata[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LINE_WIDTH:       prdata = {16'd0, cfg_reg.line_width};
            REG_CHANNEL_COUNT:    prdata = {29'd0, cfg_reg.channel_count};
            REG_COUNT_HIGH_FIRST: prdata = {31'd0, cfg_reg.count_high_first};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_width       <= 16'd1;
            cfg_reg.channel_count    <= 3'd4;
            cfg_reg.count_high_first <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pic_rle_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .in_fire (in_fire),
        .in_data (s_data),
        .push    (push)
    );

    pic_rle_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

FILE: design/pic_rle_outq.sv
`default_nettype none

module pic_rle_outq (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire pic_rle_pkg::push_t    push,
    output logic                       room,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output pic_rle_pkg::out_item_t     m_data
);
    import pic_rle_pkg::*;

    out_item_t  mem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign m_valid = (count_reg != 3'd0);
    assign m_data  = mem_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    // one byte may add two results
    assign room    = (count_reg <= 3'd2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.cnt} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.cnt == 2'd2) begin
            mem_reg[wr_ptr_reg + 2'd1] <= push.res1;
        end
    end

endmodule

`default_nettype wire

FILE: design/pic_rle_core.sv
`default_nettype none

module pic_rle_core (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire pic_rle_pkg::cfg_t     cfg,
    input  wire logic                  in_fire,
    input  wire pic_rle_pkg::in_item_t in_data,
    output pic_rle_pkg::push_t         push
);
    import pic_rle_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] run_count_reg, run_count_next;
    logic [1:0]  chan_idx_reg, chan_idx_next;
    logic [31:0] pix_val_reg, pix_val_next;
    logic [15:0] pix_done_reg, pix_done_next;
    logic [7:0]  raw_left_reg, raw_left_next;

    logic [2:0]  nch;
    logic [15:0] width;
    logic [7:0]  b;
    logic [1:0]  ci_inc;
    logic [31:0] pix_acc;
    logic        pix_fire;
    logic [15:0] left;
    logic [15:0] run_n;
    logic        done_line;
    logic        pix_valid;
    logic [15:0] pix_rep;
    logic        st_valid;
    logic [1:0]  st_code;
    out_item_t   pix_res;
    out_item_t   st_res;

    always_comb begin
        if (cfg.channel_count == 3'd0) begin
            nch = 3'd1;
        end else if (cfg.channel_count > MAX_CHANNELS) begin
            nch = MAX_CHANNELS;
        end else begin
            nch = cfg.channel_count;
        end
        width   = (cfg.line_width == 16'd0) ? 16'd1 : cfg.line_width;
        b       = in_data.data_byte;
        ci_inc  = chan_idx_reg + 2'd1;
        pix_acc = pix_val_reg | ({24'd0, b} << {chan_idx_reg, 3'b000});
        left    = (pix_done_reg < width) ? (width - pix_done_reg) : 16'd0;
        run_n   = (run_count_reg < left) ? run_count_reg : left;
    end

    // next state
    always_comb begin
        phase_next     = phase_reg;
        run_count_next = run_count_reg;
        chan_idx_next  = chan_idx_reg;
        pix_val_next   = pix_val_reg;
        pix_done_next  = pix_done_reg;
        raw_left_next  = raw_left_reg;
        pix_fire       = 1'b0;
        pix_valid      = 1'b0;
        pix_rep        = 16'd0;
        done_line      = 1'b0;
        st_valid       = 1'b0;
        st_code        = ST_PIXELS;

        if (in_fire) begin
            case (phase_reg)
                PH_HEADER: begin
                    chan_idx_next = 2'd0;
                    pix_val_next  = 32'd0;
                    if (b < LONG_HEADER) begin
                        raw_left_next = b + 8'd1;
                        phase_next    = PH_RAW_PIX;
                    end else if (b == LONG_HEADER) begin
                        run_count_next = 16'd0;
                        phase_next     = PH_COUNT_A;
                    end else begin
                        run_count_next = {8'd0, b} - RUN_BIAS;
                        phase_next     = PH_RUN_PIX;
                    end
                end
                PH_COUNT_A: begin
                    run_count_next = cfg.count_high_first ? {b, 8'd0} : {8'd0, b};
                    phase_next     = PH_COUNT_B;
                end
                PH_COUNT_B: begin
                    run_count_next = cfg.count_high_first ? {run_count_reg[15:8], b}
                                                          : {b, run_count_reg[7:0]};
                    chan_idx_next  = 2'd0;
                    pix_val_next   = 32'd0;
                    phase_next     = PH_RUN_PIX;
                end
                PH_RUN_PIX, PH_RAW_PIX: begin
                    pix_val_next  = pix_acc;
                    chan_idx_next = ci_inc;
                    pix_fire      = ({1'b0, ci_inc} >= nch) || (ci_inc == 2'd0);
                end
                default: begin
                    phase_next     = PH_HEADER;
                    run_count_next = 16'd0;
                    chan_idx_next  = 2'd0;
                    pix_val_next   = 32'd0;
                    pix_done_next  = 16'd0;
                    raw_left_next  = 8'd0;
                end
            endcase

            if (pix_fire) begin
                chan_idx_next = 2'd0;
                pix_val_next  = 32'd0;
                if (phase_reg == PH_RUN_PIX) begin
                    // run is clipped to what is left of the line
                    if (run_n != 16'd0) begin
                        pix_valid     = 1'b1;
                        pix_rep       = run_n;
                        pix_done_next = pix_done_reg + run_n;
                    end
                    phase_next = PH_HEADER;
                    done_line  = (pix_done_next >= width);
                end else begin
                    if (left != 16'd0) begin
                        pix_valid     = 1'b1;
                        pix_rep       = 16'd1;
                        pix_done_next = pix_done_reg + 16'd1;
                    end
                    raw_left_next = raw_left_reg - 8'd1;
                    if (raw_left_next == 8'd0) begin
                        phase_next = PH_HEADER;
                        done_line  = (pix_done_next >= width);
                    end
                end
            end

            if (done_line) begin
                st_valid = 1'b1;
                st_code  = ST_LINE_DONE;
            end else if (in_data.final_byte) begin
                st_valid = 1'b1;
                st_code  = (phase_next != PH_HEADER) ? ST_MID_PACKET : ST_SHORT_LINE;
            end

            // status ends the line: decoding restarts fresh
            if (st_valid) begin
                phase_next     = PH_HEADER;
                run_count_next = 16'd0;
                chan_idx_next  = 2'd0;
                pix_val_next   = 32'd0;
                pix_done_next  = 16'd0;
                raw_left_next  = 8'd0;
            end
        end
    end

    // result assembly
    always_comb begin
        pix_res.chan0        = pix_acc[7:0];
        pix_res.chan1        = pix_acc[15:8];
        pix_res.chan2        = pix_acc[23:16];
        pix_res.chan3        = pix_acc[31:24];
        pix_res.repeat_res   = pix_rep;
        pix_res.start_pixel  = pix_done_reg;
        pix_res.status       = ST_PIXELS;
        pix_res.last_of_step = !st_valid;

        st_res              = '0;
        st_res.status       = st_code;
        st_res.last_of_step = 1'b1;

        push.cnt  = {1'b0, pix_valid} + {1'b0, st_valid};
        push.res0 = pix_valid ? pix_res : st_res;
        push.res1 = st_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            run_count_reg <= 16'd0;
            chan_idx_reg  <= 2'd0;
            pix_val_reg   <= 32'd0;
            pix_done_reg  <= 16'd0;
            raw_left_reg  <= 8'd0;
        end else begin
            phase_reg     <= phase_next;
            run_count_reg <= run_count_next;
            chan_idx_reg  <= chan_idx_next;
            pix_val_reg   <= pix_val_next;
            pix_done_reg  <= pix_done_next;
            raw_left_reg  <= raw_left_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/pic_rle_checker.sv
`default_nettype none

`include "pic_mixed_rle_line_decoder_assert.svh"

module pic_rle_checker (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire pic_rle_pkg::out_item_t m_data
);
    import pic_rle_pkg::*;

    // a stalled result holds
    `PIC_RLE_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data))

    // nothing is offered right after reset
    `PIC_RLE_ASSERT_NEXT(a_reset_empty, aclk, 1'b0, !aresetn, !m_valid)

    // status results carry no pixel and always close the byte's results
    `PIC_RLE_ASSERT_SAME(a_status_clean, aclk, !aresetn,
        m_valid && (m_data.status != ST_PIXELS),
        m_data.chan0 == 8'd0 && m_data.chan1 == 8'd0 && m_data.chan2 == 8'd0 &&
        m_data.chan3 == 8'd0 && m_data.repeat_res == 16'd0 &&
        m_data.start_pixel == 16'd0 && m_data.last_of_step)

    // a pixel result always writes at least one pixel
    `PIC_RLE_ASSERT_SAME(a_pixel_count, aclk, !aresetn,
        m_valid && (m_data.status == ST_PIXELS), m_data.repeat_res != 16'd0)

endmodule

bind pic_mixed_rle_line_decoder pic_rle_checker u_pic_rle_checker (.*);

`default_nettype wire
